// File: rtl/hpe_pkg.sv
// shared types and constants of the horner polynomial evaluator
`default_nettype none
package hpe_pkg;
	localparam int MAX_COEFFS = 7;
	localparam int DATA_W = 32;
	localparam int TERMS_W = 3;
	localparam int ADDR_W = 5;
	localparam int PROD_W = 2 * DATA_W;

	localparam logic [TERMS_W-1:0] REG_TERMS = 3'd0;

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic [MAX_COEFFS-1:0][DATA_W-1:0] coef_arr_t;

	typedef struct packed {
		logic [TERMS_W-1:0] terms;
		coef_arr_t coef;
	} hpe_cfg_t;
endpackage
`default_nettype wire

// File: rtl/hpe_cfg.sv
// configuration register file with apb-style access
`default_nettype none
module hpe_cfg import hpe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output hpe_cfg_t cfg
);
	logic [TERMS_W-1:0] terms_q;
	coef_arr_t coef_q;
	logic [TERMS_W-1:0] idx;
	logic [TERMS_W-1:0] cidx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = paddr[ADDR_W-1:2];
	assign cidx = idx - 3'd1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terms_q <= '0;
			coef_q <= '0;
		end else if (wr_en) begin
			if (idx == REG_TERMS) begin
				terms_q <= pwdata[TERMS_W-1:0];
			end else begin
				coef_q[cidx] <= pwdata;
			end
		end
	end

	always_comb begin
		if (idx == REG_TERMS) begin
			prdata = {{(DATA_W-TERMS_W){1'b0}}, terms_q};
		end else begin
			prdata = coef_q[cidx];
		end
	end

	assign cfg.terms = terms_q;
	assign cfg.coef = coef_q;
endmodule
`default_nettype wire

// File: rtl/hpe_step.sv
// one horner step: multiply stage then shift, add and saturate stage
`default_nettype none
module hpe_step import hpe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [DATA_W-1:0] in_x,
	input wire logic [DATA_W-1:0] in_acc,
	input wire logic in_ovf,
	input wire logic [DATA_W-1:0] coef,
	input wire logic active,
	output logic out_valid,
	input wire logic out_ready,
	output logic [DATA_W-1:0] out_x,
	output logic [DATA_W-1:0] out_acc,
	output logic out_ovf
);
	logic v_s1;
	logic [DATA_W-1:0] x_s1;
	logic [DATA_W-1:0] acc_s1;
	logic ovf_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic ready_s1;

	logic v_s2;
	logic [DATA_W-1:0] x_s2;
	logic [DATA_W-1:0] acc_s2;
	logic ovf_s2;
	logic ready_s2;

	logic signed [PROD_W-1:0] shifted;
	logic [PROD_W:0] sum;
	logic sat;
	logic [DATA_W-1:0] step_acc;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: full-width product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			x_s1 <= in_x;
			acc_s1 <= in_acc;
			ovf_s1 <= in_ovf;
			prod_s1 <= $signed(in_acc) * $signed(in_x);
		end
	end

	// stage 2: scale, add coefficient, clamp
	always_comb begin
		shifted = prod_s1 >>> FRAC_BITS;
		sum = {shifted[PROD_W-1], shifted} + {{(PROD_W-DATA_W+1){coef[DATA_W-1]}}, coef};
		sat = !((&sum[PROD_W:DATA_W-1]) || !(|sum[PROD_W:DATA_W-1]));
		if (!sat) begin
			step_acc = sum[DATA_W-1:0];
		end else if (sum[PROD_W]) begin
			step_acc = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			step_acc = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			x_s2 <= x_s1;
			if (active) begin
				acc_s2 <= step_acc;
				ovf_s2 <= ovf_s1 | sat;
			end else begin
				acc_s2 <= acc_s1;
				ovf_s2 <= ovf_s1;
			end
		end
	end

	assign out_valid = v_s2;
	assign out_x = x_s2;
	assign out_acc = acc_s2;
	assign out_ovf = ovf_s2;
endmodule
`default_nettype wire

// File: rtl/horner_polynomial_evaluator_unit.sv
// horner polynomial evaluator top level: config registers and step pipeline
// every accepted item passes through the stages of all NUM_COEFFS steps, whatever the term count
// throughput: one item per cycle while the output is not stalled, each horner step owning a multiply and an add stage
// every stage has its own valid bit, so bubbles close up while the output is stalled
// reset: asynchronous, clears all valid bits and all configuration registers to zero
`default_nettype none
module horner_polynomial_evaluator_unit import hpe_pkg::*; #(
	parameter int NUM_COEFFS = 7,
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // [31:0] sample_in
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [31:0] poly_value
	output logic m_axis_tuser, // [0] overflow
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);
	localparam int DEPTH = 2 * NUM_COEFFS;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [TERMS_W-1:0] NUM_TERMS = TERMS_W'(NUM_COEFFS);

	hpe_cfg_t cfg;
	logic [TERMS_W-1:0] n_eff;

	logic valid_c [NUM_COEFFS+1];
	logic ready_c [NUM_COEFFS+1];
	logic [DATA_W-1:0] x_c [NUM_COEFFS+1];
	logic [DATA_W-1:0] acc_c [NUM_COEFFS+1];
	logic ovf_c [NUM_COEFFS+1];

	hpe_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign n_eff = (cfg.terms > NUM_TERMS) ? NUM_TERMS : cfg.terms;

	assign valid_c[0] = s_axis_tvalid;
	assign s_axis_tready = ready_c[0];
	assign x_c[0] = s_axis_tdata;
	assign acc_c[0] = '0;
	assign ovf_c[0] = 1'b0;

	// step k works on coefficient NUM_COEFFS-1-k
	for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_step
		localparam logic [TERMS_W-1:0] J = TERMS_W'(NUM_COEFFS - 1 - k);
		hpe_step #(
			.FRAC_BITS(FRAC_BITS)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(valid_c[k]),
			.in_ready(ready_c[k]),
			.in_x(x_c[k]),
			.in_acc(acc_c[k]),
			.in_ovf(ovf_c[k]),
			.coef(cfg.coef[J]),
			.active(n_eff > J),
			.out_valid(valid_c[k+1]),
			.out_ready(ready_c[k+1]),
			.out_x(x_c[k+1]),
			.out_acc(acc_c[k+1]),
			.out_ovf(ovf_c[k+1])
		);
	end

	assign m_axis_tvalid = valid_c[NUM_COEFFS];
	assign ready_c[NUM_COEFFS] = m_axis_tready;
	assign m_axis_tdata = acc_c[NUM_COEFFS];
	assign m_axis_tuser = ovf_c[NUM_COEFFS];

	// items in flight, kept for checking
	logic [CNT_W-1:0] cnt_q;
	logic acc_in;
	logic acc_out;

	assign acc_in = s_axis_tvalid & s_axis_tready;
	assign acc_out = m_axis_tvalid & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc_in && !acc_out) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is drained");

	a_zero_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && cfg.terms == '0) |-> (m_axis_tdata == '0 && !m_axis_tuser))
		else $error("zero terms gave a non-zero item");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("more items in flight than pipeline stages");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !m_axis_tvalid)
		else $error("output item with none accepted");
endmodule
`default_nettype wire
